// ===== rtl/core/url_escape_utf8_to_byte_decoder_macros.svh =====
// Assertion macros shared by the URL decoder RTL.
`ifndef URL_ESCAPE_UTF8_TO_BYTE_DECODER_MACROS_SVH
`define URL_ESCAPE_UTF8_TO_BYTE_DECODER_MACROS_SVH

// Clocked assertion, ignored while reset is high.
`define URLDEC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Clocked assertion that also holds across reset.
`define URLDEC_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// ===== rtl/core/urldec_pkg.sv =====
// Shared types, constants and helper functions for the URL decoder.
`timescale 1ns / 1ps

package urldec_pkg;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_PCT   = 2'd1,
      PH_DIGIT = 2'd2
   } esc_phase_type;

   localparam logic [7:0] CHR_PERCENT = 8'h25;
   localparam logic [7:0] CHR_PLUS    = 8'h2b;
   localparam logic [7:0] CHR_SPACE   = 8'h20;
   localparam logic [7:0] CHR_NUL     = 8'h00;
   localparam logic [7:0] CNT_RESET   = 8'hff;

   localparam int unsigned NUM_SLOTS = 3;

   // Hex digit value; anything that is not a hex digit counts as 0.
   function automatic logic [3:0] hex_value(input logic [7:0] c);
      logic [7:0] v;
      begin
         v = 8'h00;
         if (c >= 8'h30 && c <= 8'h39) begin
            v = c - 8'h30;
         end else if (c >= 8'h61 && c <= 8'h66) begin
            v = c - 8'h57;
         end else if (c >= 8'h41 && c <= 8'h46) begin
            v = c - 8'h37;
         end
         hex_value = v[3:0];
      end
   endfunction

   function automatic logic [7:0] plus_to_space(input logic [7:0] c);
      plus_to_space = (c == CHR_PLUS) ? CHR_SPACE : c;
   endfunction

endpackage

// ===== rtl/core/url_escape_utf8_to_byte_decoder.sv =====
// URL percent decoder with UTF-8 collapsing, top level.
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  req     | req_valid/req_stall, data_byte, is_last | in
//  rsp     | rsp_valid/rsp_stall, out_byte/valid/last| out
//
// A request is decoded from the input register into the three slot
// response register when it has room, giving zero to three responses.
// While rsp_stall is low these drain one per cycle, and a new request is
// taken every cycle if each yields at most one response. Synchronous
// reset idles escape and UTF-8 state. rsp_stall backs up into req_stall.
`timescale 1ns / 1ps

`include "url_escape_utf8_to_byte_decoder_macros.svh"

module url_escape_utf8_to_byte_decoder
   import urldec_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_is_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_valid,
   output logic       rsp_out_last
);

   // input register
   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_byte_ff;
   logic       s1_last_ff;

   // decoder state
   esc_phase_type phase_ff, phase_in;
   logic [7:0]    held_ff, held_in;
   logic [7:0]    acc_ff, acc_in;
   logic [7:0]    cnt_ff, cnt_in;

   // response slots
   logic [NUM_SLOTS-1:0] slot_valid_ff, slot_valid_in;
   logic [7:0]           slot_byte_ff [NUM_SLOTS];
   logic [7:0]           slot_byte_in [NUM_SLOTS];
   logic                 slot_data_ff [NUM_SLOTS];
   logic                 slot_data_in [NUM_SLOTS];
   logic                 grp_last_ff, grp_last_in;

   logic                 req_accept, rsp_accept, load_ok, load;
   logic                 single_left;
   logic [NUM_SLOTS-1:0] cur_sel;

   // decode signals
   logic       pct_emit, mid_en, zero_emit, mid_emit;
   logic [7:0] mid_byte, mid_out;

   assign rsp_valid   = |slot_valid_ff;
   assign rsp_accept  = rsp_valid && !rsp_stall;
   assign single_left = (slot_valid_ff & (slot_valid_ff - 1'b1)) == '0;
   assign cur_sel     = slot_valid_ff & (~slot_valid_ff + 1'b1);
   assign load_ok     = !rsp_valid || (rsp_accept && single_left);
   assign load        = s1_valid_ff && load_ok;
   assign req_stall   = s1_valid_ff && !load_ok;
   assign req_accept  = req_valid && !req_stall;

   // Escape scan: at most '%', one stateful byte, then a NUL.
   always_comb begin
      pct_emit  = 1'b0;
      mid_en    = 1'b0;
      zero_emit = 1'b0;
      mid_byte  = plus_to_space(s1_byte_ff);
      phase_in  = PH_IDLE;
      held_in   = held_ff;
      unique case (phase_ff)
         PH_PCT: begin
            if (s1_byte_ff == CHR_NUL || s1_last_ff) begin
               pct_emit = 1'b1;
               mid_en   = 1'b1;
            end else begin
               held_in  = s1_byte_ff;
               phase_in = PH_DIGIT;
            end
         end
         PH_DIGIT: begin
            mid_en = 1'b1;
            if (s1_byte_ff == CHR_NUL) begin
               pct_emit  = 1'b1;
               zero_emit = 1'b1;
               mid_byte  = plus_to_space(held_ff);
            end else begin
               mid_byte = {hex_value(held_ff), hex_value(s1_byte_ff)};
            end
         end
         default: begin
            if (s1_byte_ff == CHR_PERCENT && !s1_last_ff) begin
               phase_in = PH_PCT;
            end else begin
               mid_en = 1'b1;
            end
         end
      endcase
   end

   // UTF-8 collapse of the middle byte
   always_comb begin
      acc_in   = acc_ff;
      cnt_in   = cnt_ff;
      mid_emit = 1'b0;
      mid_out  = mid_byte;
      if (mid_en) begin
         priority if (mid_byte[7:6] == 2'b10) begin
            acc_in   = {acc_ff[1:0], mid_byte[5:0]};
            cnt_in   = cnt_ff - 8'd1;
            mid_emit = (cnt_in == 8'd0);
            mid_out  = acc_in;
         end else if (mid_byte[7] == 1'b0) begin
            mid_emit = 1'b1;
         end else if (mid_byte[7:5] == 3'b110) begin
            acc_in = mid_byte & 8'h1f;
            cnt_in = 8'd1;
         end else if (mid_byte[7:4] == 4'b1110) begin
            acc_in = mid_byte & 8'h0f;
            cnt_in = 8'd2;
         end else if (mid_byte[7:3] == 5'b11110) begin
            acc_in = mid_byte & 8'h07;
            cnt_in = 8'd3;
         end else if (mid_byte[7:2] == 6'b111110) begin
            acc_in = mid_byte & 8'h03;
            cnt_in = 8'd4;
         end else begin
            acc_in = mid_byte & 8'h01;
            cnt_in = 8'd5;
         end
      end
   end

   // response slot next values
   always_comb begin
      slot_valid_in = slot_valid_ff;
      grp_last_in   = grp_last_ff;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         slot_byte_in[i] = slot_byte_ff[i];
         slot_data_in[i] = slot_data_ff[i];
      end
      if (load) begin
         slot_valid_in   = {zero_emit, mid_emit, pct_emit};
         slot_byte_in[0] = CHR_PERCENT;
         slot_data_in[0] = 1'b1;
         slot_byte_in[1] = mid_out;
         slot_data_in[1] = 1'b1;
         slot_byte_in[2] = CHR_NUL;
         slot_data_in[2] = 1'b1;
         grp_last_in     = s1_last_ff;
         // bare end marker when the last request decodes to nothing
         if (s1_last_ff && !(zero_emit || mid_emit || pct_emit)) begin
            slot_valid_in[0] = 1'b1;
            slot_byte_in[0]  = CHR_NUL;
            slot_data_in[0]  = 1'b0;
         end
      end else if (rsp_accept) begin
         slot_valid_in = slot_valid_ff & ~cur_sel;
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (load) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         slot_valid_ff <= '0;
         grp_last_ff   <= 1'b0;
         phase_ff      <= PH_IDLE;
         held_ff       <= CHR_NUL;
         acc_ff        <= 8'd0;
         cnt_ff        <= CNT_RESET;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         slot_valid_ff <= slot_valid_in;
         grp_last_ff   <= grp_last_in;
         if (load) begin
            if (s1_last_ff) begin
               phase_ff <= PH_IDLE;
               held_ff  <= CHR_NUL;
               acc_ff   <= 8'd0;
               cnt_ff   <= CNT_RESET;
            end else begin
               phase_ff <= phase_in;
               held_ff  <= held_in;
               acc_ff   <= acc_in;
               cnt_ff   <= cnt_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_byte_ff <= req_data_byte;
         s1_last_ff <= req_is_last;
      end
      for (int i = 0; i < NUM_SLOTS; i++) begin
         slot_byte_ff[i] <= slot_byte_in[i];
         slot_data_ff[i] <= slot_data_in[i];
      end
   end

   // output select: lowest pending slot
   always_comb begin
      rsp_out_byte  = slot_byte_ff[0];
      rsp_out_valid = slot_data_ff[0];
      priority if (slot_valid_ff[0]) begin
         rsp_out_byte  = slot_byte_ff[0];
         rsp_out_valid = slot_data_ff[0];
      end else if (slot_valid_ff[1]) begin
         rsp_out_byte  = slot_byte_ff[1];
         rsp_out_valid = slot_data_ff[1];
      end else begin
         rsp_out_byte  = slot_byte_ff[2];
         rsp_out_valid = slot_data_ff[2];
      end
   end

   assign rsp_out_last = rsp_valid && grp_last_ff && single_left;

   `URLDEC_ASSERT(a_last_resets_state, load && s1_last_ff |=> phase_ff == PH_IDLE && acc_ff == 8'd0 && cnt_ff == CNT_RESET, "state not cleared after last request")
   `URLDEC_ASSERT_ALWAYS(a_stall_needs_item, req_stall |-> s1_valid_ff, "stall with empty input register")
   `URLDEC_ASSERT(a_marker_is_last, rsp_valid && !rsp_out_valid |-> rsp_out_last, "bare marker not at end of string")

endmodule

// ===== tb/url_escape_utf8_to_byte_decoder_checker.sv =====
// Checker for the URL decoder: predicts decoded bytes and compares responses.
`timescale 1ns / 1ps

module url_escape_utf8_to_byte_decoder_checker
   import urldec_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_is_last,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [7:0] rsp_out_byte,
   input  logic       rsp_out_valid,
   input  logic       rsp_out_last,
   output int         fail_count,
   output int         expected_left
);

   typedef struct packed {
      logic [7:0] data;
      logic       valid;
      logic       last;
   } decoded_byte_type;

   decoded_byte_type expected_bytes[$];
   decoded_byte_type want;

   esc_phase_type esc_state;
   logic [7:0]    first_digit;
   logic [7:0]    utf_acc;
   logic [7:0]    utf_remaining;

   function automatic logic [3:0] nibble_of(input logic [7:0] c);
      if (c inside {[8'h30:8'h39]}) return c[3:0];
      // 'a'..'f' and 'A'..'F' share the low nibble 1..6
      if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) return c[3:0] + 4'd9;
      return 4'd0;
   endfunction

   task automatic clear_state();
      esc_state     = PH_IDLE;
      first_digit   = 8'h00;
      utf_acc       = 8'h00;
      utf_remaining = 8'hff;
   endtask

   task automatic push_byte(input logic [7:0] v);
      expected_bytes.push_back('{v, 1'b1, 1'b0});
   endtask

   task automatic fold_utf8(input logic [7:0] b);
      if (b[7:6] == 2'b10) begin
         utf_acc = {utf_acc[1:0], b[5:0]};
         utf_remaining = utf_remaining - 8'd1;
         if (utf_remaining == 8'd0) push_byte(utf_acc);
      end else if (!b[7]) begin
         push_byte(b);
      end else if (b[7:5] == 3'b110) begin
         utf_acc = {3'b000, b[4:0]};
         utf_remaining = 8'd1;
      end else if (b[7:4] == 4'b1110) begin
         utf_acc = {4'b0000, b[3:0]};
         utf_remaining = 8'd2;
      end else if (b[7:3] == 5'b11110) begin
         utf_acc = {5'b00000, b[2:0]};
         utf_remaining = 8'd3;
      end else if (b[7:2] == 6'b111110) begin
         utf_acc = {6'b000000, b[1:0]};
         utf_remaining = 8'd4;
      end else begin
         utf_acc = {7'b0000000, b[0]};
         utf_remaining = 8'd5;
      end
   endtask

   task automatic take_plain(input logic [7:0] b);
      fold_utf8(b == CHR_PLUS ? CHR_SPACE : b);
   endtask

   task automatic scan_free(input logic [7:0] b, input logic last);
      if (b == CHR_PERCENT && !last) begin
         esc_state = PH_PCT;
      end else begin
         esc_state = PH_IDLE;
         take_plain(b);
      end
   endtask

   task automatic decode_request(input logic [7:0] b, input logic last);
      int first_new;
      first_new = expected_bytes.size();
      case (esc_state)
         PH_PCT: begin
            if (b == CHR_NUL || last) begin
               esc_state = PH_IDLE;
               fold_utf8(CHR_PERCENT);
               scan_free(b, last);
            end else begin
               first_digit = b;
               esc_state = PH_DIGIT;
            end
         end
         PH_DIGIT: begin
            esc_state = PH_IDLE;
            if (b == CHR_NUL) begin
               // escape cut short: replay '%', the held digit and the zero
               fold_utf8(CHR_PERCENT);
               take_plain(first_digit);
               take_plain(b);
            end else begin
               fold_utf8({nibble_of(first_digit), nibble_of(b)});
            end
         end
         default: scan_free(b, last);
      endcase
      if (last) begin
         if (expected_bytes.size() == first_new) begin
            expected_bytes.push_back('{8'h00, 1'b0, 1'b1});
         end else begin
            expected_bytes[expected_bytes.size() - 1].last = 1'b1;
         end
         clear_state();
      end
   endtask

   // Response is checked before the same-edge request is predicted.
   always @(posedge clock) begin
      if (reset) begin
         clear_state();
         expected_bytes.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_bytes.size() == 0) begin
               $error("unexpected response: out_byte %02h out_valid %0b out_last %0b",
                      rsp_out_byte, rsp_out_valid, rsp_out_last);
               fail_count++;
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_out_byte !== want.data) begin
                  $error("out_byte: expected %02h, got %02h", want.data, rsp_out_byte);
                  fail_count++;
               end
               if (rsp_out_valid !== want.valid) begin
                  $error("out_valid: expected %0b, got %0b", want.valid, rsp_out_valid);
                  fail_count++;
               end
               if (rsp_out_last !== want.last) begin
                  $error("out_last: expected %0b, got %0b", want.last, rsp_out_last);
                  fail_count++;
               end
            end
         end
         if (req_valid && !req_stall) decode_request(req_data_byte, req_is_last);
      end
      expected_left = expected_bytes.size();
   end

endmodule

// ===== tb/tb_url_escape_utf8_to_byte_decoder.sv =====
// Testbench top for the URL decoder: stimulus, back-pressure and verdict.
`timescale 1ns / 1ps

module tb_url_escape_utf8_to_byte_decoder;
   import urldec_pkg::*;

   localparam int RANDOM_ITEMS_END = 100;
   localparam int HOLD_CYCLES      = 80;
   localparam int DRAIN_CYCLES     = 20;
   localparam int CYCLE_LIMIT      = 400000;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_is_last = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_out_valid;
   logic       rsp_out_last;

   int         fail_count;
   int         expected_left;
   int         cycle_count = 0;
   int         sent_count = 0;
   int         no_gap_left = 0;
   logic       hold_rsp = 1'b0;
   logic [7:0] text_q[$];

   always #4 clock = ~clock;

   url_escape_utf8_to_byte_decoder i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_is_last   (req_is_last),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_out_valid (rsp_out_valid),
      .rsp_out_last  (rsp_out_last)
   );

   url_escape_utf8_to_byte_decoder_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_is_last   (req_is_last),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_out_valid (rsp_out_valid),
      .rsp_out_last  (rsp_out_last),
      .fail_count    (fail_count),
      .expected_left (expected_left)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit upper);
      if (nib < 4'd10) return 8'h30 + 8'(nib);
      return (upper ? 8'h41 : 8'h61) + 8'(nib) - 8'd10;
   endfunction

   task automatic push_encoded(input logic [7:0] v, input bit escaped);
      if (escaped) begin
         text_q.push_back(CHR_PERCENT);
         text_q.push_back(hex_char(v[7:4], 1'($urandom_range(0, 1))));
         text_q.push_back(hex_char(v[3:0], 1'($urandom_range(0, 1))));
      end else begin
         text_q.push_back(v);
      end
   endtask

   task automatic add_token();
      int         kind;
      int         seq_len;
      logic [7:0] rnd;
      logic [7:0] lead;
      kind = $urandom_range(0, 99);
      rnd = 8'($urandom);
      if (kind < 30) begin
         text_q.push_back(8'($urandom_range(1, 127)));
      end else if (kind < 38) begin
         text_q.push_back(CHR_PLUS);
      end else if (kind < 55) begin
         push_encoded(rnd, 1'b1);
      end else if (kind < 80) begin
         // multi-byte sequence of two to six bytes, each byte raw or escaped
         seq_len = $urandom_range(2, 6);
         case (seq_len)
            2: lead = {3'b110, rnd[4:0]};
            3: lead = {4'b1110, rnd[3:0]};
            4: lead = {5'b11110, rnd[2:0]};
            5: lead = {6'b111110, rnd[1:0]};
            default: lead = {6'b111111, rnd[1:0]};
         endcase
         push_encoded(lead, 1'($urandom_range(0, 1)));
         repeat (seq_len - 1) push_encoded({2'b10, 6'($urandom)}, 1'($urandom_range(0, 1)));
      end else if (kind < 88) begin
         text_q.push_back(rnd);
      end else if (kind < 95) begin
         // escape broken by a zero byte
         text_q.push_back(CHR_PERCENT);
         if ($urandom_range(0, 1)) text_q.push_back(8'($urandom_range(1, 255)));
         text_q.push_back(CHR_NUL);
      end else begin
         text_q.push_back(CHR_PERCENT);
         text_q.push_back(8'($urandom_range(1, 255)));
         text_q.push_back(8'($urandom_range(1, 255)));
      end
   endtask

   task automatic send_request(input logic [7:0] b, input logic last);
      int gap;
      int pick;
      gap = 0;
      if (no_gap_left > 0) begin
         no_gap_left--;
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 50) gap = 0;
         else if (pick < 82) gap = $urandom_range(1, 3);
         else if (pick < 92) gap = $urandom_range(4, 8);
         else if (pick < 96) gap = $urandom_range(15, 40);
         else no_gap_left = $urandom_range(10, 30);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      req_is_last   <= last;
      do @(posedge clock); while (req_stall);
      sent_count++;
   endtask

   task automatic send_text();
      foreach (text_q[i]) send_request(text_q[i], i == text_q.size() - 1);
   endtask

   // Response side back-pressure, with one long hold on request.
   initial begin : rsp_side
      int pick;
      int quiet_left;
      quiet_left = 0;
      wait (!reset);
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
            hold_rsp = 1'b0;
         end else if (quiet_left > 0) begin
            rsp_stall <= 1'b0;
            quiet_left--;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
               rsp_stall <= 1'b1;
               repeat ($urandom_range(10, 40)) @(posedge clock);
               rsp_stall <= 1'b0;
            end else if (pick < 8) begin
               quiet_left = $urandom_range(20, 60);
            end else begin
               rsp_stall <= (pick < 35);
            end
         end
      end
   end

   initial begin : stimulus
      bit hold_started;
      int tail;
      hold_started = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      text_q = '{CHR_PERCENT, "4", "a", CHR_PLUS};
      send_text();
      text_q = '{CHR_PERCENT};
      send_text();
      text_q = '{CHR_PERCENT, CHR_NUL};
      send_text();
      text_q = '{CHR_PERCENT, CHR_PERCENT, CHR_NUL};
      send_text();
      // held '+' replays as space; lone lead byte at end gives a bare end marker
      text_q = '{CHR_PERCENT, CHR_PLUS, CHR_NUL, 8'hff};
      send_text();
      // stray continuation from reset, then a two-byte sequence and a non-hex digit
      text_q = '{8'h80, 8'hc3, 8'ha9, CHR_PERCENT, "g", "1"};
      send_text();
      text_q = '{8'hf8, 8'h88, 8'h80, 8'h80, 8'hbf};
      send_text();

      while (sent_count < RANDOM_ITEMS_END) begin
         if (!hold_started && sent_count > 60) begin
            hold_started = 1'b1;
            hold_rsp = 1'b1;
            no_gap_left = 40;
         end
         text_q.delete();
         repeat ($urandom_range(1, 6)) add_token();
         // sometimes the string ends inside an escape
         tail = $urandom_range(0, 9);
         if (tail == 0) begin
            text_q.push_back(CHR_PERCENT);
         end else if (tail == 1) begin
            text_q.push_back(CHR_PERCENT);
            text_q.push_back(8'($urandom_range(1, 255)));
         end
         send_text();
      end

      req_valid <= 1'b0;
      @(posedge clock);
      wait (expected_left == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
